/* hw/rtl/ycrgb_pkg.sv */
// Package for the YCbCr to RGB converter with ordered dither.
// Holds the BT.601 coefficients, the dither matrix and the per-channel finishing function.
// No dependencies.
package ycrgb_pkg;

	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned PHASE_W   = 2;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned DITHER_W  = 4;
	localparam int unsigned SUM_W     = 20;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 1'd1;

	localparam logic signed [SUM_W-1:0] COEF_Y     = 20'sd298;
	localparam logic signed [SUM_W-1:0] COEF_R_CR  = 20'sd409;
	localparam logic signed [SUM_W-1:0] COEF_G_CB  = 20'sd100;
	localparam logic signed [SUM_W-1:0] COEF_G_CR  = 20'sd208;
	localparam logic signed [SUM_W-1:0] COEF_B_CB  = 20'sd516;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = 20'sd128;
	localparam logic signed [SUM_W-1:0] LUMA_OFS   = 20'sd16;
	localparam logic signed [SUM_W-1:0] CHROMA_OFS = 20'sd128;
	localparam logic [CHAN_W-1:0]       TOP_FOUR_MASK = 8'hF0;
	localparam logic [CHAN_W-1:0]       CHAN_MAX   = 8'hFF;

	localparam logic [DITHER_W-1:0] DITHER_MATRIX [4][4] = '{
		'{4'd15, 4'd7,  4'd13, 4'd5},
		'{4'd3,  4'd11, 4'd1,  4'd9},
		'{4'd12, 4'd4,  4'd14, 4'd6},
		'{4'd0,  4'd8,  4'd2,  4'd10}
	};

	// Floor shift by 8 and clamp to 0..255, then optional 4-bit mask and dither.
	function automatic logic [CHAN_W-1:0] finish_channel(
		input logic signed [SUM_W-1:0] sum,
		input logic                    four_bit,
		input logic                    dither_on,
		input logic [DITHER_W-1:0]     dith
	);
		logic [CHAN_W-1:0] v;
		logic [CHAN_W:0]   t;
		if (sum[SUM_W-1]) begin
			v = '0;
		end else if (|sum[SUM_W-2:CHAN_W+8]) begin
			v = CHAN_MAX;
		end else begin
			v = sum[CHAN_W+7:8];
		end
		if (four_bit) begin
			v = v & TOP_FOUR_MASK;
			if (dither_on) begin
				t = {1'b0, v} + {{(CHAN_W+1-DITHER_W){1'b0}}, dith};
				v = t[CHAN_W] ? CHAN_MAX : t[CHAN_W-1:0];
			end
		end
		return v;
	endfunction

endpackage

/* hw/rtl/ycbcr_to_rgb_dither_unit.sv */
// Top level of the BT.601 YCbCr to RGB converter with 4-bit mode and ordered dither.
// Depends on ycrgb_pkg for coefficients, the dither matrix and channel finishing.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel item: luma, chroma_blue,
//   chroma_red and the row and column phase of the pixel for the dither matrix.
//   Output channel (out_valid/out_ready) carries red, green and blue.
//   The configuration port writes four_bit_mode (index 0) and dither_enable
//   (index 1) at any edge where cfg_write is high; the user must make writes
//   only while idle; the block itself does not enforce it.
// Throughput: one item per cycle while out_ready stays high. The item goes into an
//   input register, through one pass of constant multiplies, sums and clamps, into
//   the output register, and is offered on the output from there.
// Stalls: when out_ready is low the output register holds its item; the input
//   register still takes one more item, after which in_ready falls until the
//   output is taken. in_ready depends combinationally on out_ready.
// Reset: arst_n clears both valid flags and both configuration registers.
module ycbcr_to_rgb_dither_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [ycrgb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ycrgb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]     luma,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]     chroma_blue,
	input  logic [ycrgb_pkg::SAMPLE_W-1:0]     chroma_red,
	input  logic [ycrgb_pkg::PHASE_W-1:0]      row_phase,
	input  logic [ycrgb_pkg::PHASE_W-1:0]      col_phase,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ycrgb_pkg::CHAN_W-1:0]       red,
	output logic [ycrgb_pkg::CHAN_W-1:0]       green,
	output logic [ycrgb_pkg::CHAN_W-1:0]       blue
);
	import ycrgb_pkg::*;

	logic four_bit_mode_q;
	logic dither_enable_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] luma_s1;
	logic [SAMPLE_W-1:0] cb_s1;
	logic [SAMPLE_W-1:0] cr_s1;
	logic [PHASE_W-1:0]  row_s1;
	logic [PHASE_W-1:0]  col_s1;

	logic              valid_s2;
	logic [CHAN_W-1:0] red_s2;
	logic [CHAN_W-1:0] green_s2;
	logic [CHAN_W-1:0] blue_s2;

	logic ready_s2;
	logic ready_s1;

	logic signed [SUM_W-1:0] c_term;
	logic signed [SUM_W-1:0] d_term;
	logic signed [SUM_W-1:0] e_term;
	logic signed [SUM_W-1:0] y_prod;
	logic signed [SUM_W-1:0] red_sum;
	logic signed [SUM_W-1:0] green_sum;
	logic signed [SUM_W-1:0] blue_sum;
	logic [DITHER_W-1:0]     dith;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_mode_q <= 1'b0;
			dither_enable_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FOUR_BIT_MODE: four_bit_mode_q <= cfg_data[0];
				REG_DITHER_ENABLE: dither_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			luma_s1 <= luma;
			cb_s1   <= chroma_blue;
			cr_s1   <= chroma_red;
			row_s1  <= row_phase;
			col_s1  <= col_phase;
		end
	end

	// Offsets removed, then the shared luma product feeds all three sums.
	always_comb begin
		c_term    = $signed({{(SUM_W-SAMPLE_W){1'b0}}, luma_s1}) - LUMA_OFS;
		d_term    = $signed({{(SUM_W-SAMPLE_W){1'b0}}, cb_s1}) - CHROMA_OFS;
		e_term    = $signed({{(SUM_W-SAMPLE_W){1'b0}}, cr_s1}) - CHROMA_OFS;
		y_prod    = COEF_Y * c_term;
		red_sum   = y_prod + COEF_R_CR * e_term + ROUND_HALF;
		green_sum = y_prod - COEF_G_CB * d_term - COEF_G_CR * e_term + ROUND_HALF;
		blue_sum  = y_prod + COEF_B_CB * d_term + ROUND_HALF;
		dith      = DITHER_MATRIX[row_s1][col_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			red_s2   <= finish_channel(red_sum, four_bit_mode_q, dither_enable_q, dith);
			green_s2 <= finish_channel(green_sum, four_bit_mode_q, dither_enable_q, dith);
			blue_s2  <= finish_channel(blue_sum, four_bit_mode_q, dither_enable_q, dith);
		end
	end

	assign out_valid = valid_s2;
	assign red       = red_s2;
	assign green     = green_s2;
	assign blue      = blue_s2;

	// An item in the input register moves on whenever the output side has room.
	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("input stage item was not moved to output stage");

	// The input side only stalls when both stages are full.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	// Four-bit mode without dither leaves the low nibble of every channel clear.
	a_four_bit_mask: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && four_bit_mode_q && !dither_enable_q |=>
		red_s2[3:0] == 4'd0 && green_s2[3:0] == 4'd0 && blue_s2[3:0] == 4'd0)
		else $error("four-bit mode result has low bits set");

	// A stalled result is not overwritten by the item behind it.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(red_s2) && $stable(green_s2)
		&& $stable(blue_s2))
		else $error("stalled result was overwritten");

endmodule
